// ===== design/sfir_pkg.sv =====
// shared types and constants of the separable 2-d fir filter
package sfir_pkg;

   localparam int SAMPLE_W = 16;
   localparam int ADDEND_W = 24;
   localparam int COEF_W   = 16;
   localparam int ROW_W    = 20;
   localparam int OUT_W    = 24;
   localparam int CSR_W    = 64;
   localparam int CSR_IDX_W = 3;
   localparam int COEFS_PER_REG = 4;
   localparam int COEF_REG_TAPS = 8;
   localparam int FRAC_BITS = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_TAPS     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_TAPS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ADD_MODE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COEFS_LO = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COEFS_HI = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COEFS_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_COL_COEFS_HI = 3'd7;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_H_RUN,
      ST_H_DRAIN1,
      ST_H_DRAIN2,
      ST_H_ROUND,
      ST_V_RUN,
      ST_V_DRAIN1,
      ST_V_DRAIN2,
      ST_V_ROUND,
      ST_UPDATE
   } ctrl_state_type;

   typedef struct packed {
      logic take;
      logic issue_h;
      logic issue_v;
      logic h_round;
      logic out_load;
      logic update;
   } dp_cmd_type;

   typedef struct packed {
      logic do_row;
      logic do_out;
      logic h_last;
      logic v_last;
      logic out_free;
   } dp_status_type;

endpackage

// ===== design/sfir_ram.sv =====
// generic simple dual port ram with registered read
module sfir_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 7168
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/sfir_ctrl.sv =====
// sequencer that steps one item through the row and column passes
module sfir_ctrl
   import sfir_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = status.do_row ? ST_H_RUN : ST_UPDATE;
         end
         ST_H_RUN: begin
            if (status.h_last) state_in = ST_H_DRAIN1;
         end
         ST_H_DRAIN1: state_in = ST_H_DRAIN2;
         ST_H_DRAIN2: state_in = ST_H_ROUND;
         ST_H_ROUND: begin
            state_in = status.do_out ? ST_V_RUN : ST_UPDATE;
         end
         ST_V_RUN: begin
            if (status.v_last) state_in = ST_V_DRAIN1;
         end
         ST_V_DRAIN1: state_in = ST_V_DRAIN2;
         ST_V_DRAIN2: state_in = ST_V_ROUND;
         ST_V_ROUND: begin
            if (status.out_free) state_in = ST_UPDATE;
         end
         ST_UPDATE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            // no item is taken while reset is held
            req_stall = reset;
            cmd.take = req_valid && !reset;
         end
         ST_H_RUN:   cmd.issue_h = 1'b1;
         ST_H_ROUND: cmd.h_round = 1'b1;
         ST_V_RUN:   cmd.issue_v = 1'b1;
         ST_V_ROUND: cmd.out_load = status.out_free;
         ST_UPDATE:  cmd.update = 1'b1;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// ===== design/sfir_datapath.sv =====
// registers, shared multiply-accumulate, line store and output register
module sfir_datapath
   import sfir_pkg::*;
#(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_TAPS  = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_W-1:0]              csr_write_data,
   input  logic signed [SAMPLE_W-1:0]    req_sample,
   input  logic signed [ADDEND_W-1:0]    req_addend,
   input  logic                          req_frame_start,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [OUT_W-1:0]       rsp_filtered_value,
   output logic [$clog2(MAX_WIDTH)-1:0]  rsp_out_column,
   output logic                          rsp_row_end,
   input  dp_cmd_type                    cmd,
   output dp_status_type                 status
);

   localparam int NSLOTS = MAX_TAPS - 1;
   localparam int CW     = $clog2(MAX_WIDTH);
   localparam int WW     = $clog2(MAX_WIDTH + 1);
   localparam int TW     = $clog2(MAX_TAPS + 1);
   localparam int KW     = $clog2(MAX_TAPS);
   localparam int AW     = $clog2(NSLOTS * MAX_WIDTH);
   localparam int IWW    = (WW > 11) ? WW : 11;
   localparam int TCW    = (TW > 4) ? TW : 4;
   localparam int CMPW   = ((CW > TW) ? CW : TW) + 1;
   localparam int LW     = ((CW > WW) ? CW : WW) + 1;
   localparam int PROD_W = ROW_W + COEF_W;
   localparam int ACC_W  = PROD_W + $clog2(MAX_TAPS) + 1;
   localparam int RW     = ACC_W - FRAC_BITS;

   localparam logic signed [ACC_W-1:0] RND = ACC_W'(2 ** (FRAC_BITS - 1));
   localparam logic signed [RW-1:0] ROW_MAX = RW'((2 ** (ROW_W - 1)) - 1);
   localparam logic signed [RW-1:0] ROW_MIN = RW'(-(2 ** (ROW_W - 1)));
   localparam logic signed [RW:0]   OUT_MAX = (RW + 1)'((2 ** (OUT_W - 1)) - 1);
   localparam logic signed [RW:0]   OUT_MIN = (RW + 1)'(-(2 ** (OUT_W - 1)));

   // configuration
   logic [10:0]      image_width_ff;
   logic [3:0]       row_taps_ff;
   logic [3:0]       col_taps_ff;
   logic             add_mode_ff;
   logic [CSR_W-1:0] row_coefs_lo_ff, row_coefs_hi_ff;
   logic [CSR_W-1:0] col_coefs_lo_ff, col_coefs_hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= 11'd1024;
         row_taps_ff     <= 4'd1;
         col_taps_ff     <= 4'd1;
         add_mode_ff     <= 1'b0;
         row_coefs_lo_ff <= '0;
         row_coefs_hi_ff <= '0;
         col_coefs_lo_ff <= '0;
         col_coefs_hi_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_write_data[10:0];
            CSR_ROW_TAPS:     row_taps_ff     <= csr_write_data[3:0];
            CSR_COL_TAPS:     col_taps_ff     <= csr_write_data[3:0];
            CSR_ADD_MODE:     add_mode_ff     <= csr_write_data[0];
            CSR_ROW_COEFS_LO: row_coefs_lo_ff <= csr_write_data;
            CSR_ROW_COEFS_HI: row_coefs_hi_ff <= csr_write_data;
            CSR_COL_COEFS_LO: col_coefs_lo_ff <= csr_write_data;
            CSR_COL_COEFS_HI: col_coefs_hi_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // clamped settings
   logic [WW-1:0] width_eff;
   logic [TW-1:0] rt;
   logic [TW-1:0] ct;

   always_comb begin
      if (image_width_ff == 11'd0) width_eff = WW'(1);
      else if (IWW'(image_width_ff) > IWW'(MAX_WIDTH)) width_eff = WW'(MAX_WIDTH);
      else width_eff = WW'(image_width_ff);
      if (row_taps_ff == 4'd0) rt = TW'(1);
      else if (TCW'(row_taps_ff) > TCW'(MAX_TAPS)) rt = TW'(MAX_TAPS);
      else rt = TW'(row_taps_ff);
      if (col_taps_ff == 4'd0) ct = TW'(1);
      else if (TCW'(col_taps_ff) > TCW'(MAX_TAPS)) ct = TW'(MAX_TAPS);
      else ct = TW'(col_taps_ff);
   end

   logic signed [COEF_W-1:0] rcoef [MAX_TAPS];
   logic signed [COEF_W-1:0] ccoef [MAX_TAPS];
   logic [2*CSR_W-1:0]       row_coefs;
   logic [2*CSR_W-1:0]       col_coefs;

   assign row_coefs = {row_coefs_hi_ff, row_coefs_lo_ff};
   assign col_coefs = {col_coefs_hi_ff, col_coefs_lo_ff};

   always_comb begin
      for (int i = 0; i < MAX_TAPS; i++) begin
         if (i < COEF_REG_TAPS) begin
            rcoef[i] = row_coefs[(i % COEF_REG_TAPS)*COEF_W +: COEF_W];
            ccoef[i] = col_coefs[(i % COEF_REG_TAPS)*COEF_W +: COEF_W];
         end else begin
            rcoef[i] = '0;
            ccoef[i] = '0;
         end
      end
   end

   // frame position
   logic [CW-1:0] col_ff;
   logic [KW-1:0] rows_ff;
   logic [KW-1:0] slot_ff;
   logic [CW-1:0] col_eff;
   logic [KW-1:0] rows_eff;
   logic [KW-1:0] slot_eff;

   assign col_eff  = req_frame_start ? '0 : col_ff;
   assign rows_eff = req_frame_start ? '0 : rows_ff;
   assign slot_eff = req_frame_start ? '0 : slot_ff;

   // current item
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [ADDEND_W-1:0] addend_ff;
   logic                       do_row_ff;
   logic                       do_out_ff;
   logic                       last_ff;
   logic [CW-1:0]              p_ff;
   logic signed [SAMPLE_W-1:0] win_ff [NSLOTS];
   logic [KW-1:0]              k_ff;
   logic signed [ROW_W-1:0]    rv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff    <= '0;
         rows_ff   <= '0;
         slot_ff   <= '0;
         do_row_ff <= 1'b0;
         do_out_ff <= 1'b0;
         last_ff   <= 1'b0;
         k_ff      <= '0;
      end else begin
         if (cmd.take) begin
            col_ff    <= col_eff;
            rows_ff   <= rows_eff;
            slot_ff   <= slot_eff;
            do_row_ff <= (CMPW'(col_eff) + CMPW'(1) >= CMPW'(rt));
            do_out_ff <= (CMPW'(col_eff) + CMPW'(1) >= CMPW'(rt)) &&
                         (TCW'(rows_eff) + TCW'(1) >= TCW'(ct));
            last_ff   <= (LW'(col_eff) + LW'(1) >= LW'(width_eff));
            k_ff      <= '0;
         end else if (cmd.issue_h) begin
            k_ff <= status.h_last ? '0 : k_ff + KW'(1);
         end else if (cmd.issue_v) begin
            k_ff <= status.v_last ? '0 : k_ff + KW'(1);
         end else if (cmd.update) begin
            if (last_ff) begin
               col_ff  <= '0;
               slot_ff <= (slot_ff == KW'(NSLOTS - 1)) ? '0 : slot_ff + KW'(1);
               if (rows_ff < KW'(NSLOTS)) rows_ff <= rows_ff + KW'(1);
            end else begin
               col_ff <= col_ff + CW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         sample_ff <= req_sample;
         addend_ff <= req_addend;
         p_ff      <= CW'(CMPW'(col_eff) + CMPW'(1) - CMPW'(rt));
      end
      if (cmd.update) begin
         win_ff[0] <= sample_ff;
         for (int i = 1; i < NSLOTS; i++) begin
            win_ff[i] <= win_ff[i-1];
         end
      end
   end

   assign status.do_row = do_row_ff;
   assign status.do_out = do_out_ff;
   assign status.h_last = (TW'(k_ff) + TW'(1) == rt);
   assign status.v_last = (TW'(k_ff) + TW'(1) == ct);

   // operand selection
   logic [KW-1:0]  win_idx;
   logic [TW-1:0]  age;
   logic [TW:0]    slot_sum;
   logic [KW-1:0]  rd_slot;
   logic [AW-1:0]  rd_addr;
   logic [AW-1:0]  wr_addr;
   logic [ROW_W-1:0] rd_data;

   assign win_idx  = KW'(rt - TW'(2) - TW'(k_ff));
   assign age      = ct - TW'(1) - TW'(k_ff);
   assign slot_sum = (TW + 1)'(slot_ff) + (TW + 1)'(NSLOTS) - (TW + 1)'(age);
   // wrap the slot back into range
   assign rd_slot  = (slot_sum >= (TW + 1)'(NSLOTS)) ?
                     KW'(slot_sum - (TW + 1)'(NSLOTS)) : KW'(slot_sum);
   assign rd_addr  = AW'(rd_slot) * AW'(MAX_WIDTH) + AW'(p_ff);
   assign wr_addr  = AW'(slot_ff) * AW'(MAX_WIDTH) + AW'(p_ff);

   sfir_ram #(
      .WIDTH (ROW_W),
      .DEPTH (NSLOTS * MAX_WIDTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (cmd.update && do_row_ff),
      .wr_addr (wr_addr),
      .wr_data (rv_ff),
      .rd_en   (cmd.issue_v && !status.v_last),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // multiply-accumulate pipe: operand, product, accumulate
   logic                      s0_valid_ff;
   logic                      s0_mem_ff;
   logic signed [ROW_W-1:0]   s0_dir_ff;
   logic signed [COEF_W-1:0]  s0_coef_ff;
   logic                      prod_valid_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [ROW_W-1:0]   mul_a;

   assign mul_a = s0_mem_ff ? $signed(rd_data) : s0_dir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff   <= cmd.issue_h || cmd.issue_v;
         prod_valid_ff <= s0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.issue_h) begin
         s0_mem_ff  <= 1'b0;
         s0_dir_ff  <= status.h_last ? ROW_W'(sample_ff) : ROW_W'(win_ff[win_idx]);
         s0_coef_ff <= rcoef[k_ff];
      end else if (cmd.issue_v) begin
         s0_mem_ff  <= !status.v_last;
         s0_dir_ff  <= rv_ff;
         s0_coef_ff <= ccoef[k_ff];
      end
      prod_ff <= mul_a * s0_coef_ff;
      if (cmd.take || cmd.h_round || cmd.out_load) begin
         acc_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
   end

   // rounding and saturation
   logic signed [ACC_W-1:0] acc_rnd;
   logic signed [RW-1:0]    acc_sh;
   logic signed [RW:0]      out_sum;
   logic signed [ROW_W-1:0] row_sat;
   logic signed [OUT_W-1:0] out_sat;

   assign acc_rnd = acc_ff + RND;
   assign acc_sh  = RW'(acc_rnd >>> FRAC_BITS);
   assign out_sum = (RW + 1)'(acc_sh) +
                    (add_mode_ff ? (RW + 1)'(addend_ff) : (RW + 1)'(0));

   always_comb begin
      if (acc_sh > ROW_MAX) row_sat = ROW_W'(ROW_MAX);
      else if (acc_sh < ROW_MIN) row_sat = ROW_W'(ROW_MIN);
      else row_sat = ROW_W'(acc_sh);
      if (out_sum > OUT_MAX) out_sat = OUT_W'(OUT_MAX);
      else if (out_sum < OUT_MIN) out_sat = OUT_W'(OUT_MIN);
      else out_sat = OUT_W'(out_sum);
   end

   always_ff @(posedge clock) begin
      if (cmd.h_round) rv_ff <= row_sat;
   end

   // output register
   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_value_ff;
   logic [CW-1:0]           rsp_column_ff;
   logic                    rsp_row_end_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_value_ff   <= out_sat;
         rsp_column_ff  <= p_ff;
         rsp_row_end_ff <= last_ff;
      end
   end

   assign status.out_free    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_filtered_value = rsp_value_ff;
   assign rsp_out_column     = rsp_column_ff;
   assign rsp_row_end        = rsp_row_end_ff;

endmodule

// ===== design/separable_2d_fir_filter_core.sv =====
// top level of the separable 2-d fir filter
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/stall   | sample, addend, frame_start
//  rsp     | out       | rsp_valid/stall   | filtered_value, out_column, row_end
//  csr     | in        | csr_write_enable  | csr_index, csr_write_data
//
// one item at a time through a shared 20x16 multiplier: each item passes idle, decide
// and update, plus a row pass when a row value is formed and a column pass when an
// output is formed (one tap per cycle, then the multiply pipe drains, then rounding).
// reset is synchronous; the line store needs no clearing after reset.
// a result waits in the output register while the next item is taken; only a
// second result stalls, in the column rounding state, until the first one leaves.
module separable_2d_fir_filter_core
   import sfir_pkg::*;
#(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_TAPS  = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_W-1:0]              csr_write_data,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [SAMPLE_W-1:0]    req_sample,
   input  logic signed [ADDEND_W-1:0]    req_addend,
   input  logic                          req_frame_start,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [OUT_W-1:0]       rsp_filtered_value,
   output logic [$clog2(MAX_WIDTH)-1:0]  rsp_out_column,
   output logic                          rsp_row_end
);

   dp_cmd_type    cmd;
   dp_status_type status;

   sfir_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   sfir_datapath #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_TAPS  (MAX_TAPS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .req_sample         (req_sample),
      .req_addend         (req_addend),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_filtered_value (rsp_filtered_value),
      .rsp_out_column     (rsp_out_column),
      .rsp_row_end        (rsp_row_end),
      .cmd                (cmd),
      .status             (status)
   );

endmodule

// ===== bench/separable_2d_fir_filter_core_tb.sv =====
// testbench of the separable 2-d fir filter core: predicted results vs. the rtl
module separable_2d_fir_filter_core_tb;
   import sfir_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WIDTH = 1024;
   localparam int MAX_TAPS  = 8;
   localparam int NSLOTS    = MAX_TAPS - 1;
   localparam int SETTLE    = 40;
   localparam int STUCK_LIMIT = 3000;
   localparam int HOLD_CYCLES = 400;
   localparam int WIDE_ITEMS  = 320;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [ADDEND_W-1:0] addend;
      logic                       frame_start;
   } pixel_t;

   typedef struct {
      logic signed [OUT_W-1:0] value;
      logic [9:0]              column;
      logic                    row_end;
   } filt_out_t;

   logic clock = 0;
   logic reset = 1;
   logic csr_write_enable = 0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_W-1:0] csr_write_data = '0;
   logic req_valid = 0;
   logic req_stall;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic signed [ADDEND_W-1:0] req_addend = '0;
   logic req_frame_start = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [OUT_W-1:0] rsp_filtered_value;
   logic [9:0] rsp_out_column;
   logic rsp_row_end;

   separable_2d_fir_filter_core #(.MAX_WIDTH(MAX_WIDTH), .MAX_TAPS(MAX_TAPS)) u_top (
      .clock(clock), .reset(reset),
      .csr_write_enable(csr_write_enable), .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid), .req_stall(req_stall), .req_sample(req_sample),
      .req_addend(req_addend), .req_frame_start(req_frame_start),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_filtered_value(rsp_filtered_value), .rsp_out_column(rsp_out_column),
      .rsp_row_end(rsp_row_end)
   );

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   // filter state mirrored here
   logic [10:0] m_width = 11'd1024;
   logic [3:0]  m_row_taps = 4'd1, m_col_taps = 4'd1;
   logic        m_add = 0;
   logic [63:0] m_row_lo = '0, m_row_hi = '0, m_col_lo = '0, m_col_hi = '0;
   longint line_rows [NSLOTS][MAX_WIDTH];
   longint recent_px [NSLOTS];
   int col_pos = 0, rows_done = 0, cur_slot = 0;

   pixel_t    pixel_q[$];
   filt_out_t filt_q[$];
   int errors = 0;
   int cyc = 0;
   int stuck = 0;
   logic req_took = 0;
   logic hold_go = 0, hold_done = 0;
   int hold_left = 0;
   wire quiet = cyc >= 4000 && cyc < 7000;

   function automatic int clampi(int v, int lo, int hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint tap_weight(logic [63:0] lo, logic [63:0] hi, int k);
      logic [15:0] h;
      h = (k < 4) ? lo[16*k +: 16] : hi[16*(k-4) +: 16];
      return longint'(signed'(h));
   endfunction

   function automatic longint round_q14(longint x);
      return (x + 8192) >>> FRAC_BITS;
   endfunction

   function automatic longint saturate(longint x, int bits);
      longint top;
      top = (longint'(1) <<< (bits - 1)) - 1;
      return x > top ? top : (x < -top - 1 ? -top - 1 : x);
   endfunction

   function automatic void filter_pixel(pixel_t px);
      int w, rt, ct, c, p, slot, k;
      longint s, acc, rv, v;
      logic last;
      filt_out_t r;
      w  = clampi(m_width, 1, MAX_WIDTH);
      rt = clampi(m_row_taps, 1, MAX_TAPS);
      ct = clampi(m_col_taps, 1, MAX_TAPS);
      s  = px.sample;
      if (px.frame_start) begin
         col_pos = 0;
         rows_done = 0;
         cur_slot = 0;
      end
      c = col_pos;
      last = c >= w - 1;
      if (c >= rt - 1) begin
         p = c - (rt - 1);
         acc = s * tap_weight(m_row_lo, m_row_hi, rt - 1);
         for (k = 0; k + 1 < rt; k++)
            acc += recent_px[rt - 2 - k] * tap_weight(m_row_lo, m_row_hi, k);
         rv = saturate(round_q14(acc), ROW_W);
         if (rows_done >= ct - 1) begin
            v = rv * tap_weight(m_col_lo, m_col_hi, ct - 1);
            for (k = 0; k + 1 < ct; k++) begin
               slot = (cur_slot + NSLOTS - (ct - 1 - k)) % NSLOTS;
               v += line_rows[slot][p] * tap_weight(m_col_lo, m_col_hi, k);
            end
            v = round_q14(v);
            if (m_add) v += longint'(px.addend);
            v = saturate(v, OUT_W);
            r.value = v[OUT_W-1:0];
            r.column = p[9:0];
            r.row_end = last;
            filt_q.push_back(r);
         end
         line_rows[cur_slot][p] = rv;
      end
      for (k = NSLOTS - 1; k > 0; k--) recent_px[k] = recent_px[k - 1];
      recent_px[0] = s;
      if (last) begin
         col_pos = 0;
         cur_slot = (cur_slot + 1) % NSLOTS;
         if (rows_done < NSLOTS) rows_done++;
      end else begin
         col_pos = c + 1;
      end
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch on %s at cycle %0d: got %0d, expected %0d", what, cyc, got, want);
      errors++;
   endtask

   // driver
   always @(negedge clock) begin
      pixel_t px;
      logic idle;
      idle = !quiet && $urandom_range(0, 99) < 30;
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || req_took) begin
         if (pixel_q.size() > 0 && !idle) begin
            px = pixel_q.pop_front();
            req_valid <= 1;
            req_sample <= px.sample;
            req_addend <= px.addend;
            req_frame_start <= px.frame_start;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // receiver stall, with one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1;
         hold_left <= hold_left - 1;
      end else if (hold_go && !hold_done) begin
         rsp_stall <= 1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1;
      end else begin
         rsp_stall <= !quiet && $urandom_range(0, 99) < 30;
      end
   end

   // acceptance, monitor and watchdog
   always @(posedge clock) begin
      pixel_t px;
      filt_out_t want;
      cyc <= cyc + 1;
      req_took <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         px.sample = req_sample;
         px.addend = req_addend;
         px.frame_start = req_frame_start;
         filter_pixel(px);
      end
      if (!reset && rsp_valid && !rsp_stall) begin
         if (filt_q.size() == 0) begin
            $display("unexpected result at cycle %0d: value %0d column %0d",
                     cyc, rsp_filtered_value, rsp_out_column);
            errors++;
         end else begin
            want = filt_q.pop_front();
            if (rsp_filtered_value !== want.value)
               report_mismatch("filtered_value", rsp_filtered_value, want.value);
            if (rsp_out_column !== want.column)
               report_mismatch("out_column", rsp_out_column, want.column);
            if (rsp_row_end !== want.row_end)
               report_mismatch("row_end", rsp_row_end, want.row_end);
         end
      end
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable || reset)
         stuck <= 0;
      else
         stuck <= stuck + 1;
      if (stuck >= STUCK_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      case (idx)
         CSR_IMAGE_WIDTH:  m_width = data[10:0];
         CSR_ROW_TAPS:     m_row_taps = data[3:0];
         CSR_COL_TAPS:     m_col_taps = data[3:0];
         CSR_ADD_MODE:     m_add = data[0];
         CSR_ROW_COEFS_LO: m_row_lo = data;
         CSR_ROW_COEFS_HI: m_row_hi = data;
         CSR_COL_COEFS_LO: m_col_lo = data;
         default:          m_col_hi = data;
      endcase
      @(negedge clock);
      csr_write_enable <= 0;
   endtask

   // sender pauses until everything is out, then the block settles
   task automatic drain_wait();
      while (pixel_q.size() > 0 || req_valid || filt_q.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_sample();
      case ($urandom_range(0, 9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(0, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] pick_addend();
      case ($urandom_range(0, 9))
         0: return 24'h800000;
         1: return 24'h7fffff;
         2: return '0;
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic logic [63:0] pick_coefs();
      logic [63:0] r;
      int k;
      for (k = 0; k < COEFS_PER_REG; k++)
         case ($urandom_range(0, 7))
            0: r[16*k +: 16] = 16'h8000;
            1: r[16*k +: 16] = 16'h7fff;
            2: r[16*k +: 16] = 16'h4000;
            3: r[16*k +: 16] = 16'($urandom_range(0, 4095)) - 16'd2048;
            default: r[16*k +: 16] = 16'($urandom);
         endcase
      return r;
   endfunction

   function automatic int queue_rows(int width, int rows, logic new_frame);
      pixel_t px;
      int r, c;
      for (r = 0; r < rows; r++)
         for (c = 0; c < width; c++) begin
            px.sample = pick_sample();
            px.addend = pick_addend();
            // occasional restart in the middle of a frame
            px.frame_start = (new_frame && r == 0 && c == 0) || $urandom_range(0, 59) == 0;
            pixel_q.push_back(px);
         end
      return width * rows;
   endfunction

   initial begin
      pixel_t px;
      int n_items, w_reg, w, ct, rows, iter, i;
      logic have_frame;
      n_items = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // defaults after reset: one tap each way, zero weights
      for (i = 0; i < 3; i++) begin
         px.sample = (i == 0) ? 16'h7fff : 16'h8000;
         px.addend = pick_addend();
         px.frame_start = (i == 0);
         pixel_q.push_back(px);
      end
      n_items += 3;
      drain_wait();

      // extreme weights and samples, add mode saturating both ways
      write_reg(CSR_IMAGE_WIDTH, 64'd4);
      write_reg(CSR_ROW_TAPS, 64'd2);
      write_reg(CSR_COL_TAPS, 64'd2);
      write_reg(CSR_ADD_MODE, 64'd1);
      write_reg(CSR_ROW_COEFS_LO, 64'h0000_0000_8000_8000);
      write_reg(CSR_ROW_COEFS_HI, 64'h7fff_7fff_7fff_7fff);
      write_reg(CSR_COL_COEFS_LO, 64'h0000_0000_7fff_8000);
      write_reg(CSR_COL_COEFS_HI, 64'h8000_8000_8000_8000);
      for (i = 0; i < 12; i++) begin
         px.sample = (i % 3 == 0) ? 16'h7fff : 16'h8000;
         px.addend = (i % 2) ? 24'h7fffff : 24'h800000;
         px.frame_start = (i == 0);
         pixel_q.push_back(px);
      end
      n_items += 12;
      drain_wait();

      // width below the window: rows complete but give nothing; width register zero
      write_reg(CSR_IMAGE_WIDTH, 64'd0);
      write_reg(CSR_ROW_TAPS, 64'd15);
      n_items += queue_rows(1, 4, 1);
      drain_wait();

      have_frame = 0;
      iter = 0;
      while (n_items < 560) begin
         if (iter == 3) begin
            // long stretch of a clamped wide row with the widest window,
            // receiver held off meanwhile
            write_reg(CSR_IMAGE_WIDTH, 64'd2047);
            write_reg(CSR_ROW_TAPS, 64'd8);
            write_reg(CSR_COL_TAPS, 64'd0);
            write_reg(CSR_ADD_MODE, 64'($urandom_range(0, 1)));
            write_reg(CSR_ROW_COEFS_LO, pick_coefs());
            write_reg(CSR_ROW_COEFS_HI, pick_coefs());
            hold_go = 1;
            n_items += queue_rows(WIDE_ITEMS, 1, 1);
            have_frame = 0;
         end else if (have_frame && $urandom_range(0, 4) == 0) begin
            // weights and mode change between rows of a running frame
            write_reg(CSR_ADD_MODE, 64'($urandom_range(0, 1)));
            write_reg(CSR_ROW_COEFS_LO, pick_coefs());
            write_reg(CSR_COL_COEFS_HI, pick_coefs());
            n_items += queue_rows(clampi(m_width, 1, MAX_WIDTH), $urandom_range(1, 2), 0);
         end else begin
            case ($urandom_range(0, 9))
               0: w_reg = 0;
               1, 2: w_reg = $urandom_range(13, 30);
               default: w_reg = $urandom_range(1, 12);
            endcase
            write_reg(CSR_IMAGE_WIDTH, 64'(w_reg));
            write_reg(CSR_ROW_TAPS, 64'($urandom_range(0, 15)));
            write_reg(CSR_COL_TAPS, 64'($urandom_range(0, 15)));
            write_reg(CSR_ADD_MODE, 64'($urandom_range(0, 1)));
            write_reg(CSR_ROW_COEFS_LO, pick_coefs());
            write_reg(CSR_ROW_COEFS_HI, pick_coefs());
            write_reg(CSR_COL_COEFS_LO, pick_coefs());
            write_reg(CSR_COL_COEFS_HI, pick_coefs());
            w = clampi(w_reg, 1, MAX_WIDTH);
            ct = clampi(m_col_taps, 1, MAX_TAPS);
            rows = ct - 1 + $urandom_range(1, 3);
            if (w * rows > 150) rows = clampi(150 / w, 1, rows);
            n_items += queue_rows(w, rows, 1);
            have_frame = 1;
         end
         drain_wait();
         iter++;
      end

      drain_wait();
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
